@@ hdl/whp_pkg.sv @@
// Package for the WAVE header parser: phase codes, tags and the result record.
package whp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_FMT    = 3'd1,
    PH_TAG    = 3'd2,
    PH_SIZE   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_RIFF  = 2'd1,
    ST_NOT_WAVE  = 2'd2,
    ST_FMT_SHORT = 2'd3
  } status_t;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_RIFX = 32'h5249_4658;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] FMT_MIN  = 32'd16;

  localparam int RES_W   = 227;
  localparam int TDATA_W = 232;

  // Lowest field last, so status lands in bits [1:0] when packed.
  typedef struct packed {
    logic [31:0] data_size;
    logic [31:0] second_chunk_tag;
    logic [15:0] bits_per_sample;
    logic [15:0] block_align;
    logic [31:0] byte_rate;
    logic [31:0] sample_rate;
    logic [15:0] num_channels;
    logic [15:0] audio_format;
    logic [31:0] riff_size;
    logic        big_endian;
    status_t     status;
  } result_t;

  function automatic logic [31:0] swap32(input logic [31:0] w);
    swap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [15:0] swap16(input logic [15:0] w);
    swap16 = {w[7:0], w[15:8]};
  endfunction

endpackage

@@ hdl/whp_core.sv @@
// Parser state, field capture and result formation for one byte per beat.
module whp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       in_byte,
  input  logic             in_start,
  output logic             res_valid,
  output whp_pkg::result_t res
);

  whp_pkg::phase_t phase, phase_next, cur_phase;
  logic [31:0] pos, pos_next, cur_pos;
  logic        endian, endian_next, cur_endian;
  logic [31:0] asm_word, asm_word_next, cur_asm;
  logic [31:0] fmt_len, fmt_len_next, cur_fmt_len;
  logic [31:0] outer_size, outer_size_next, cur_outer_size;
  logic [15:0] fmt_code, fmt_code_next, cur_fmt_code;
  logic [15:0] channels, channels_next, cur_channels;
  logic [31:0] rate, rate_next, cur_rate;
  logic [31:0] bps, bps_next, cur_bps;
  logic [15:0] frame_bytes, frame_bytes_next, cur_frame_bytes;
  logic [15:0] sample_bits, sample_bits_next, cur_sample_bits;
  logic [31:0] tag, tag_next, cur_tag;
  logic [31:0] w32;
  logic [15:0] w16;
  whp_pkg::status_t res_status;
  logic [31:0] res_dsize;

  always_comb begin
    if (in_start) begin
      cur_phase       = whp_pkg::PH_HEADER;
      cur_pos         = '0;
      cur_endian      = 1'b0;
      cur_asm         = '0;
      cur_fmt_len     = '0;
      cur_outer_size  = '0;
      cur_fmt_code    = '0;
      cur_channels    = '0;
      cur_rate        = '0;
      cur_bps         = '0;
      cur_frame_bytes = '0;
      cur_sample_bits = '0;
      cur_tag         = '0;
    end else begin
      cur_phase       = phase;
      cur_pos         = pos;
      cur_endian      = endian;
      cur_asm         = asm_word;
      cur_fmt_len     = fmt_len;
      cur_outer_size  = outer_size;
      cur_fmt_code    = fmt_code;
      cur_channels    = channels;
      cur_rate        = rate;
      cur_bps         = bps;
      cur_frame_bytes = frame_bytes;
      cur_sample_bits = sample_bits;
      cur_tag         = tag;
    end

    phase_next       = cur_phase;
    pos_next         = cur_pos;
    endian_next      = cur_endian;
    asm_word_next    = cur_asm;
    fmt_len_next     = cur_fmt_len;
    outer_size_next  = cur_outer_size;
    fmt_code_next    = cur_fmt_code;
    channels_next    = cur_channels;
    rate_next        = cur_rate;
    bps_next         = cur_bps;
    frame_bytes_next = cur_frame_bytes;
    sample_bits_next = cur_sample_bits;
    tag_next         = cur_tag;
    res_valid        = 1'b0;
    res_status       = whp_pkg::ST_OK;
    res_dsize        = '0;

    asm_word_next = {cur_asm[23:0], in_byte};
    w32 = cur_endian ? asm_word_next : whp_pkg::swap32(asm_word_next);
    w16 = cur_endian ? asm_word_next[15:0] : whp_pkg::swap16(asm_word_next[15:0]);

    unique case (cur_phase)
      whp_pkg::PH_HEADER: begin
        pos_next = cur_pos + 32'd1;
        if (cur_pos == 32'd3) begin
          if (asm_word_next == whp_pkg::TAG_RIFX) begin
            endian_next = 1'b1;
          end else if (asm_word_next != whp_pkg::TAG_RIFF) begin
            res_valid  = 1'b1;
            res_status = whp_pkg::ST_NOT_RIFF;
          end
        end else if (cur_pos == 32'd7) begin
          outer_size_next = w32;
        end else if (cur_pos == 32'd11) begin
          if (asm_word_next != whp_pkg::TAG_WAVE) begin
            res_valid  = 1'b1;
            res_status = whp_pkg::ST_NOT_WAVE;
          end
        end else if (cur_pos == 32'd19) begin
          fmt_len_next = w32;
          if (w32 < whp_pkg::FMT_MIN) begin
            res_valid  = 1'b1;
            res_status = whp_pkg::ST_FMT_SHORT;
          end else begin
            phase_next = whp_pkg::PH_FMT;
            pos_next   = '0;
          end
        end
      end
      whp_pkg::PH_FMT: begin
        pos_next = cur_pos + 32'd1;
        if (cur_pos == 32'd1)  fmt_code_next    = w16;
        if (cur_pos == 32'd3)  channels_next    = w16;
        if (cur_pos == 32'd7)  rate_next        = w32;
        if (cur_pos == 32'd11) bps_next         = w32;
        if (cur_pos == 32'd13) frame_bytes_next = w16;
        if (cur_pos == 32'd15) sample_bits_next = w16;
        if (cur_pos == cur_fmt_len - 32'd1) begin
          phase_next = whp_pkg::PH_TAG;
          pos_next   = '0;
        end
      end
      whp_pkg::PH_TAG: begin
        pos_next = cur_pos + 32'd1;
        if (cur_pos == 32'd3) begin
          tag_next   = asm_word_next;
          phase_next = whp_pkg::PH_SIZE;
          pos_next   = '0;
        end
      end
      whp_pkg::PH_SIZE: begin
        pos_next = cur_pos + 32'd1;
        if (cur_pos == 32'd3) begin
          res_valid = 1'b1;
          res_dsize = w32;
        end
      end
      default: begin
        // hold everything once a result has gone out
        asm_word_next = cur_asm;
      end
    endcase

    if (res_valid) begin
      phase_next = whp_pkg::PH_DONE;
    end

    res.status           = res_status;
    res.big_endian       = endian_next;
    res.riff_size        = outer_size_next;
    res.audio_format     = fmt_code_next;
    res.num_channels     = channels_next;
    res.sample_rate      = rate_next;
    res.byte_rate        = bps_next;
    res.block_align      = frame_bytes_next;
    res.bits_per_sample  = sample_bits_next;
    res.second_chunk_tag = tag_next;
    res.data_size        = res_dsize;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= whp_pkg::PH_HEADER;
      pos         <= '0;
      endian      <= 1'b0;
      asm_word    <= '0;
      fmt_len     <= '0;
      outer_size  <= '0;
      fmt_code    <= '0;
      channels    <= '0;
      rate        <= '0;
      bps         <= '0;
      frame_bytes <= '0;
      sample_bits <= '0;
      tag         <= '0;
    end else if (step) begin
      phase       <= phase_next;
      pos         <= pos_next;
      endian      <= endian_next;
      asm_word    <= asm_word_next;
      fmt_len     <= fmt_len_next;
      outer_size  <= outer_size_next;
      fmt_code    <= fmt_code_next;
      channels    <= channels_next;
      rate        <= rate_next;
      bps         <= bps_next;
      frame_bytes <= frame_bytes_next;
      sample_bits <= sample_bits_next;
      tag         <= tag_next;
    end
  end

endmodule

@@ hdl/whp_out.sv @@
// Result register with a skid entry driving the master-side stream.
module whp_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  whp_pkg::result_t            push_data,
  output logic                        full,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [whp_pkg::TDATA_W-1:0] m_axis_tdata
);

  logic             main_valid;
  logic             skid_valid;
  whp_pkg::result_t main_data;
  whp_pkg::result_t skid_data;
  logic             pop;

  assign pop           = main_valid && m_axis_tready;
  assign full          = skid_valid;
  assign m_axis_tvalid = main_valid;
  assign m_axis_tdata  = {{(whp_pkg::TDATA_W - whp_pkg::RES_W){1'b0}}, main_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push && main_valid && !pop) begin
      skid_valid <= 1'b1;
    end else if (push) begin
      main_valid <= 1'b1;
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push && main_valid && !pop) begin
      skid_data <= push_data;
    end else if (push) begin
      main_data <= push_data;
    end
  end

endmodule

@@ hdl/wave_header_parser.sv @@
// Top level of the WAVE header parser: input register, parser core, result stage.
//
// Takes one file byte per beat (tuser marks the first byte of a new file and
// restarts the parser) and emits one result beat when the header has been read
// through the size field of the chunk after fmt, or as soon as a bad RIFF/RIFX
// tag, a bad WAVE tag or an fmt chunk shorter than 16 bytes is seen. After a
// result, bytes give nothing until the next start. Throughput is one byte per
// clock: the byte sits in an input register, the parser forms its next state
// from it combinationally, and the result lands in a two-entry output register,
// so input is only held back when both output entries are waiting. A byte's
// result passes through the input register and then the output register.
module wave_header_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // data_byte
  input  logic                        s_axis_tuser,  // start_of_file
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status[1:0], big_endian, riff_size, audio_format, num_channels, sample_rate,
  // byte_rate, block_align, bits_per_sample, second_chunk_tag, data_size, pad
  output logic [whp_pkg::TDATA_W-1:0] m_axis_tdata
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_start;
  logic             full;
  logic             advance;
  logic             res_valid;
  whp_pkg::result_t res;

  assign advance       = in_valid && !full;
  assign s_axis_tready = !in_valid || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  whp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .in_byte  (in_byte),
    .in_start (in_start),
    .res_valid(res_valid),
    .res      (res)
  );

  whp_out u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (advance && res_valid),
    .push_data    (res),
    .full         (full),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

@@ tb/sv/wave_check_pkg.sv @@
// Header predictor and result scoreboard for the WAVE header parser bench.
`timescale 1ns / 100ps
package wave_check_pkg;
  import whp_pkg::*;

  class wave_scoreboard;
    phase_t      phase;
    bit [31:0]   offset;
    bit [31:0]   shift_word;
    bit [31:0]   fmt_len;
    result_t     fields;
    result_t     expected_q[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned bytes_parsed;
    int unsigned status_count[4];

    function new();
      mismatches = 0;
      results_seen = 0;
      bytes_parsed = 0;
      foreach (status_count[i]) status_count[i] = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_HEADER;
      offset = '0;
      shift_word = '0;
      fmt_len = '0;
      fields = '0;
    endfunction

    function bit [31:0] host32();
      if (fields.big_endian) return shift_word;
      return {shift_word[7:0], shift_word[15:8], shift_word[23:16], shift_word[31:24]};
    endfunction

    function bit [15:0] host16();
      if (fields.big_endian) return shift_word[15:0];
      return {shift_word[7:0], shift_word[15:8]};
    endfunction

    function void conclude(status_t code, bit [31:0] chunk_size);
      result_t res;
      res = fields;
      res.status = code;
      res.data_size = chunk_size;
      expected_q.push_back(res);
      phase = PH_DONE;
    endfunction

    function void note_byte(bit [7:0] b, bit sof);
      bit [31:0] at;
      if (sof) restart();
      if (phase == PH_DONE) return;
      bytes_parsed++;
      shift_word = {shift_word[23:0], b};
      at = offset;
      offset = at + 1;
      case (phase)
        PH_HEADER: begin
          if (at == 3) begin
            if (shift_word == TAG_RIFX) fields.big_endian = 1'b1;
            else if (shift_word != TAG_RIFF) conclude(ST_NOT_RIFF, '0);
          end else if (at == 7) begin
            fields.riff_size = host32();
          end else if (at == 11) begin
            if (shift_word != TAG_WAVE) conclude(ST_NOT_WAVE, '0);
          end else if (at == 19) begin
            fmt_len = host32();
            if (fmt_len < FMT_MIN) begin
              conclude(ST_FMT_SHORT, '0);
            end else begin
              phase = PH_FMT;
              offset = '0;
            end
          end
        end
        PH_FMT: begin
          case (at)
            1:  fields.audio_format = host16();
            3:  fields.num_channels = host16();
            7:  fields.sample_rate = host32();
            11: fields.byte_rate = host32();
            13: fields.block_align = host16();
            15: fields.bits_per_sample = host16();
            default: ;
          endcase
          if (at == fmt_len - 1) begin
            phase = PH_TAG;
            offset = '0;
          end
        end
        PH_TAG: begin
          if (at == 3) begin
            fields.second_chunk_tag = shift_word;
            phase = PH_SIZE;
            offset = '0;
          end
        end
        PH_SIZE: begin
          if (at == 3) conclude(ST_OK, host32());
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task compare(string name, logic [31:0] got, bit [31:0] want);
      if (got !== want)
        report($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    task check_result(logic [TDATA_W-1:0] beat);
      result_t got;
      result_t want;
      got = beat[RES_W-1:0];
      if (expected_q.size() == 0) begin
        report($sformatf("result beat %h with no header pending", beat));
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      status_count[int'(want.status)]++;
      compare("status", 32'(got.status), 32'(want.status));
      compare("big_endian", 32'(got.big_endian), 32'(want.big_endian));
      compare("riff_size", got.riff_size, want.riff_size);
      compare("audio_format", 32'(got.audio_format), 32'(want.audio_format));
      compare("num_channels", 32'(got.num_channels), 32'(want.num_channels));
      compare("sample_rate", got.sample_rate, want.sample_rate);
      compare("byte_rate", got.byte_rate, want.byte_rate);
      compare("block_align", 32'(got.block_align), 32'(want.block_align));
      compare("bits_per_sample", 32'(got.bits_per_sample), 32'(want.bits_per_sample));
      compare("second_chunk_tag", got.second_chunk_tag, want.second_chunk_tag);
      compare("data_size", got.data_size, want.data_size);
      compare("pad", 32'(beat[TDATA_W-1:RES_W]), '0);
    endtask
  endclass

endpackage

@@ tb/sv/wave_header_parser_test.sv @@
// Top-level bench for the WAVE header parser: byte stimulus, stalls and checks.
`timescale 1ns / 100ps
module wave_header_parser_test;
  import whp_pkg::*;
  import wave_check_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int BYTE_TARGET = 1750;
  localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  logic               clk = 1'b0;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;

  wave_scoreboard sb;
  bit [8:0]       byte_q[$];
  int unsigned    burst_left = 0;
  int unsigned    files_sent = 0;
  int unsigned    bytes_sent = 0;
  int unsigned    rx_tick = 0;
  int unsigned    stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  wave_header_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Receiver: always ready, random stalls, then long stall runs.
  always @(negedge clk) begin : rx_pattern
    bit rdy;
    case ((rx_tick / 200) % 3)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          rdy = 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(1, 30);
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
        end
      end
    endcase
    rx_tick++;
    m_axis_tready <= rdy;
  end

  initial begin : watchdog
    int idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("Watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void push_byte(bit [7:0] b, bit sof);
    byte_q.push_back({sof, b});
  endfunction

  function automatic void push_tag(bit [31:0] tag, bit sof);
    push_byte(tag[31:24], sof);
    push_byte(tag[23:16], 1'b0);
    push_byte(tag[15:8], 1'b0);
    push_byte(tag[7:0], 1'b0);
  endfunction

  function automatic void push_word(bit [31:0] v, bit big);
    if (big) push_tag(v, 1'b0);
    else push_tag({v[7:0], v[15:8], v[23:16], v[31:24]}, 1'b0);
  endfunction

  function automatic bit [31:0] near_tag(bit [31:0] tag);
    if ($urandom_range(0, 1) == 0) return $urandom;
    return tag ^ (32'h1 << $urandom_range(0, 31));
  endfunction

  task automatic send_beat(bit [8:0] item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item[7:0];
    s_axis_tuser  <= item[8];
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_queued();
    while (byte_q.size() != 0) send_beat(byte_q.pop_front());
  endtask

  // Hold input until every pending header has produced its result.
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic build_file();
    int          kind;
    int          fill;
    int          body_len;
    int          cut;
    bit          big;
    bit          huge;
    bit [31:0]   tag;
    bit [31:0]   fmt_len;
    kind = $urandom_range(0, 99);
    big  = 1'($urandom_range(0, 1));
    fill = $urandom_range(0, 9);
    huge = 1'b0;
    if (kind >= 95) begin
      repeat ($urandom_range(1, 10)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    tag = big ? TAG_RIFX : TAG_RIFF;
    if (kind < 8) tag = near_tag(tag);
    push_tag(tag, $urandom_range(0, 29) != 0);
    push_word($urandom, big);
    push_tag((kind >= 8 && kind < 16) ? near_tag(TAG_WAVE) : TAG_WAVE, 1'b0);
    push_tag(($urandom_range(0, 3) != 0) ? TAG_FMT : $urandom, 1'b0);
    if (kind >= 16 && kind < 24) begin
      fmt_len = $urandom_range(0, 15);
    end else if (kind >= 24 && kind < 27) begin
      fmt_len = $urandom | 32'h8000_0000;
      huge = 1'b1;
    end else if (kind >= 27 && kind < 50) begin
      fmt_len = 16 + $urandom_range(1, 24);
    end else begin
      fmt_len = 16;
    end
    push_word(fmt_len, big);
    body_len = huge ? $urandom_range(0, 40) : ((fmt_len < 16) ? 0 : int'(fmt_len));
    repeat (body_len) begin
      case (fill)
        0: push_byte(8'h00, 1'b0);
        1: push_byte(8'hFF, 1'b0);
        default: push_byte(8'($urandom), 1'b0);
      endcase
    end
    if (!huge) begin
      push_tag(($urandom_range(0, 1) == 0) ? TAG_DATA : $urandom, 1'b0);
      case (fill)
        0: push_word(32'h0000_0000, big);
        1: push_word(32'hFFFF_FFFF, big);
        default: push_word($urandom, big);
      endcase
    end
    if (kind >= 85 && kind < 95) begin
      cut = $urandom_range(1, byte_q.size());
      while (byte_q.size() > cut) void'(byte_q.pop_back());
    end
    repeat ($urandom_range(0, 4)) push_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no start flag after reset, tag off by one bit in its last byte, then ignored bytes
    push_tag(32'h5249_4647, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    void'(byte_q.pop_back());
    push_byte(8'h00, 1'b0);
    // big-endian header with a bad WAVE tag and an all-ones size
    push_tag(TAG_RIFX, 1'b1);
    push_word(32'hFFFF_FFFF, 1'b1);
    push_tag(32'h5741_5646, 1'b0);
    // little-endian header whose fmt length is one short
    push_tag(TAG_RIFF, 1'b1);
    push_word(32'h0000_0000, 1'b0);
    push_tag(TAG_WAVE, 1'b0);
    send_queued();
    push_tag(TAG_FMT, 1'b0);
    push_word(32'd15, 1'b0);
    send_queued();
    drain_results();

    while (bytes_sent < BYTE_TARGET) begin
      build_file();
      send_queued();
      files_sent++;
      if (files_sent % 15 == 0) drain_results();
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Ran %0d files, %0d bytes sent, %0d header bytes parsed, %0d results checked",
             files_sent, bytes_sent, sb.bytes_parsed, sb.results_seen);
    $display("Status mix: ok %0d, bad riff %0d, bad wave %0d, short fmt %0d",
             sb.status_count[0], sb.status_count[1], sb.status_count[2],
             sb.status_count[3]);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
